>>> src/tbh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the take-back-half flywheel controller.
// No dependencies; imported by tbh_mul and flywheel_take_back_half_controller.
package tbh_pkg;

    localparam int unsigned CNT_W      = 32;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned VEL_W      = 16;
    localparam int unsigned ERR_W      = VEL_W + 1;
    localparam int unsigned DRV_W      = 25;
    localparam int unsigned GAIN_W     = 24;
    localparam int unsigned TPR_W      = 12;
    localparam int unsigned PWR_W      = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    // shared shift-add multiplier
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 24;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    // velocity divider: |dcount|*60000 over dms*ticks, 16 quotient bits
    localparam int unsigned NUM_W     = 47;
    localparam int unsigned DEN_W     = TIME_W + TPR_W;
    localparam int unsigned QUO_W     = VEL_W;
    localparam int unsigned DV_W      = DEN_W + QUO_W - 1;
    localparam int unsigned DIV_CNT_W = 4;

    localparam int unsigned GPROD_W = GAIN_W + VEL_W;
    localparam int unsigned MPROD_W = 32;
    localparam int unsigned MOT_W   = 7;

    localparam logic [MUL_B_W-1:0] RPM_SCALE   = 24'd60000;
    localparam logic [DRV_W-1:0]   FULL_DRIVE  = 25'd16777216;
    localparam logic [MPROD_W-1:0] HALF_LSB    = 32'd8388608;
    localparam logic [MOT_W-1:0]   MOTOR_MAX   = 7'd127;
    localparam logic [VEL_W-1:0]   VEL_POS_MAX = 16'h7FFF;
    localparam logic [VEL_W-1:0]   VEL_NEG_MIN = 16'h8000;

    localparam logic [GAIN_W-1:0] GAIN_RESET  = 24'd4194;
    localparam logic [TPR_W-1:0]  TPR_RESET   = 12'd261;
    localparam logic [PWR_W-1:0]  POWER_RESET = 7'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOP_GAIN = 2'd0,
        CFG_REV_TICKS = 2'd1,
        CFG_MAX_POWER = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_SET    = 1'b0,
        CMD_SAMPLE = 1'b1
    } command_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_ND,
        S_DIV,
        S_VEL,
        S_ERR_START,
        S_ERR_WAIT,
        S_DRIVE,
        S_MOT_START,
        S_MOT_WAIT
    } state_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               busy;
        logic [MUL_P_W-1:0] product;
    } mul_rsp_t;

endpackage

>>> src/tbh_mul.sv
`timescale 1ns / 1ps
// Serial shift-add multiplier, one multiplier bit per cycle, early exit.
// Depends on tbh_pkg (widths, request/response structs).
module tbh_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  tbh_pkg::mul_req_t req,
    output tbh_pkg::mul_rsp_t rsp
);
    import tbh_pkg::*;

    logic [MUL_P_W-1:0] acc_reg, acc_next;
    logic [MUL_P_W-1:0] a_reg, a_next;
    logic [MUL_B_W-1:0] b_reg, b_next;

    always_comb
    begin
        acc_next = acc_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        if (req.start)
        begin
            acc_next = '0;
            a_next   = {{(MUL_P_W-MUL_A_W){1'b0}}, req.a};
            b_next   = req.b;
        end
        else if (b_reg != '0)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next = {a_reg[MUL_P_W-2:0], 1'b0};
            b_next = {1'b0, b_reg[MUL_B_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            a_reg   <= '0;
            b_reg   <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
        end
    end

    assign rsp.busy    = (b_reg != '0);
    assign rsp.product = acc_reg;

    a_zero_b_done: assert property (@(posedge clk) disable iff (!rst_n)
        req.start && req.b == '0 |=> !rsp.busy)
        else $error("multiplier busy after start with zero multiplier");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start && req.b != '0 |=> rsp.busy)
        else $error("multiplier not busy after start");
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !req.start && !rsp.busy |=> !rsp.busy && $stable(rsp.product))
        else $error("idle multiplier changed its product");

endmodule

>>> src/flywheel_take_back_half_controller.sv
`timescale 1ns / 1ps
// Take-back-half flywheel velocity controller, top level.
// Depends on tbh_pkg and tbh_mul.
//
// Input (in_valid/in_ready): command 0 sets target_rpm and the open_loop_drive
// estimate; command 1 is a control tick with encoder_count and time_ms. Every
// input transaction yields one output transaction (out_valid/out_ready) with
// motor_command, measured_rpm and crossed.
// Config (cfg_valid/cfg_ready, always ready): cfg_index 0 loop_gain, 1 encoder
// ticks per revolution, 2 max_power; other indexes ignored. Write only idle.
// Steps from accept to out_valid: a set runs the serial scaling by max_power;
// a tick runs the count and time products, a restoring divide, velocity and
// error, the gain product, the drive update and the scaling; a tick with zero
// elapsed time skips the divide and the velocity update.
// One item in work at a time; in_ready returns the cycle after the result is
// loaded.
// Reset: config registers return to defaults, drive 0, first-crossing armed.
// Output stall: the result holds in the output register; a finished item
// waits in its last state until the register frees up.
module flywheel_take_back_half_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             command,
    input  logic signed [tbh_pkg::VEL_W-1:0] target_rpm,
    input  logic [tbh_pkg::DRV_W-1:0]        open_loop_drive,
    input  logic signed [tbh_pkg::CNT_W-1:0] encoder_count,
    input  logic [tbh_pkg::TIME_W-1:0]       time_ms,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tbh_pkg::MOT_W-1:0]        motor_command,
    output logic signed [tbh_pkg::VEL_W-1:0] measured_rpm,
    output logic                             crossed,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tbh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbh_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tbh_pkg::*;

    function automatic logic [1:0] sign_code(input logic [ERR_W-1:0] x);
        logic [1:0] c;
        if (x == '0)
        begin
            c = 2'b00;
        end
        else if (x[ERR_W-1])
        begin
            c = 2'b11;
        end
        else
        begin
            c = 2'b01;
        end
        return c;
    endfunction

    state_t state_reg, state_next;

    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [TPR_W-1:0]  tpr_reg, tpr_next;
    logic [PWR_W-1:0]  power_reg, power_next;

    logic [VEL_W-1:0]  target_reg, target_next;
    logic [VEL_W-1:0]  measured_reg, measured_next;
    logic [ERR_W-1:0]  prev_err_reg, prev_err_next;
    logic [DRV_W-1:0]  drive_reg, drive_next;
    logic [DRV_W-1:0]  estimate_reg, estimate_next;
    logic [DRV_W-1:0]  held_reg, held_next;
    logic              first_reg, first_next;
    logic [CNT_W-1:0]  prev_count_reg, prev_count_next;
    logic [TIME_W-1:0] prev_time_reg, prev_time_next;

    logic                 out_valid_reg, out_valid_next;
    logic [MOT_W-1:0]     motor_reg, motor_next;
    logic [VEL_W-1:0]     rpm_reg, rpm_next;
    logic                 crossed_out_reg, crossed_out_next;

    logic                 neg_reg, neg_next;
    logic                 dms_zero_reg, dms_zero_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [DV_W-1:0]      dv_reg, dv_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [ERR_W-1:0]     err_reg, err_next;
    logic                 crossed_reg, crossed_next;

    mul_req_t mul0_req, mul1_req;
    mul_rsp_t mul0_rsp, mul1_rsp;

    logic              in_fire;
    logic [TIME_W-1:0] dms;
    logic [CNT_W-1:0]  denc;
    logic [CNT_W-1:0]  denc_mag;
    logic [TPR_W-1:0]  tpr_eff;
    logic [DRV_W-1:0]  est_sat;
    logic              div_ge;
    logic [ERR_W-1:0]  err_calc;
    logic [GPROD_W-1:0] gprod;
    logic [GPROD_W:0]   drive_sum;
    logic [DRV_W-1:0]   drive_clip;
    logic [DRV_W:0]     drive_avg;
    logic [DRV_W-1:0]   drive_new;
    logic               sign_change;
    logic [MPROD_W-1:0] motor_sum;
    logic [MOT_W:0]     motor_raw;
    logic               out_free;

    tbh_mul u_mul0 (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul0_req),
        .rsp   (mul0_rsp)
    );

    tbh_mul u_mul1 (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul1_req),
        .rsp   (mul1_rsp)
    );

    assign in_ready      = (state_reg == S_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign motor_command = motor_reg;
    assign measured_rpm  = rpm_reg;
    assign crossed       = crossed_out_reg;
    assign out_free      = !out_valid_reg || out_ready;

    assign dms      = time_ms - prev_time_reg;
    assign denc     = encoder_count - prev_count_reg;
    assign denc_mag = denc[CNT_W-1] ? (~denc + 1'b1) : denc;
    assign tpr_eff  = (tpr_reg == '0) ? {{(TPR_W-1){1'b0}}, 1'b1} : tpr_reg;
    assign est_sat  = (open_loop_drive > FULL_DRIVE) ? FULL_DRIVE : open_loop_drive;

    assign div_ge   = ({{(DV_W-NUM_W){1'b0}}, rem_reg} >= dv_reg);
    assign err_calc = {target_reg[VEL_W-1], target_reg}
                    - {measured_reg[VEL_W-1], measured_reg};

    assign gprod     = mul0_rsp.product[GPROD_W-1:0];
    assign drive_sum = {{(GPROD_W+1-DRV_W){1'b0}}, drive_reg} + {1'b0, gprod};
    assign sign_change = (sign_code(err_reg) != sign_code(prev_err_reg));
    assign drive_avg = {1'b0, drive_clip} + {1'b0, held_reg};
    assign motor_sum = mul0_rsp.product[MPROD_W-1:0] + HALF_LSB;
    assign motor_raw = motor_sum[MPROD_W-1:MPROD_W-MOT_W-1];

    always_comb
    begin
        if (!err_reg[ERR_W-1])
        begin
            if (drive_sum > {{(GPROD_W+1-DRV_W){1'b0}}, FULL_DRIVE})
            begin
                drive_clip = FULL_DRIVE;
            end
            else
            begin
                drive_clip = drive_sum[DRV_W-1:0];
            end
        end
        else if (gprod > {{(GPROD_W-DRV_W){1'b0}}, drive_reg})
        begin
            drive_clip = '0;
        end
        else
        begin
            drive_clip = drive_reg - gprod[DRV_W-1:0];
        end

        if (!sign_change)
        begin
            drive_new = drive_clip;
        end
        else if (first_reg)
        begin
            drive_new = estimate_reg;
        end
        else
        begin
            drive_new = drive_avg[DRV_W:1];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        gain_next        = gain_reg;
        tpr_next         = tpr_reg;
        power_next       = power_reg;
        target_next      = target_reg;
        measured_next    = measured_reg;
        prev_err_next    = prev_err_reg;
        drive_next       = drive_reg;
        estimate_next    = estimate_reg;
        held_next        = held_reg;
        first_next       = first_reg;
        prev_count_next  = prev_count_reg;
        prev_time_next   = prev_time_reg;
        out_valid_next   = out_valid_reg;
        motor_next       = motor_reg;
        rpm_next         = rpm_reg;
        crossed_out_next = crossed_out_reg;
        neg_next         = neg_reg;
        dms_zero_next    = dms_zero_reg;
        rem_next         = rem_reg;
        dv_next          = dv_reg;
        quo_next         = quo_reg;
        div_cnt_next     = div_cnt_reg;
        err_next         = err_reg;
        crossed_next     = crossed_reg;
        mul0_req         = '0;
        mul1_req         = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LOOP_GAIN: gain_next  = cfg_data[GAIN_W-1:0];
                CFG_REV_TICKS: tpr_next   = cfg_data[TPR_W-1:0];
                CFG_MAX_POWER: power_next = cfg_data[PWR_W-1:0];
                default:       ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    crossed_next = 1'b0;
                    if (command == CMD_SAMPLE)
                    begin
                        prev_time_next  = time_ms;
                        prev_count_next = encoder_count;
                        neg_next        = denc[CNT_W-1];
                        dms_zero_next   = (dms == '0);
                        mul0_req.start  = 1'b1;
                        mul0_req.a      = denc_mag;
                        mul0_req.b      = RPM_SCALE;
                        mul1_req.start  = 1'b1;
                        mul1_req.a      = dms;
                        mul1_req.b      = {{(MUL_B_W-TPR_W){1'b0}}, tpr_eff};
                        state_next      = S_MUL_ND;
                    end
                    else
                    begin
                        target_next   = target_rpm;
                        prev_err_next = {target_rpm[VEL_W-1], target_rpm}
                                      - {measured_reg[VEL_W-1], measured_reg};
                        estimate_next = est_sat;
                        first_next    = 1'b1;
                        held_next     = '0;
                        mul0_req.start = 1'b1;
                        mul0_req.a     = {{(MUL_A_W-DRV_W){1'b0}}, drive_reg};
                        mul0_req.b     = {{(MUL_B_W-PWR_W){1'b0}}, power_reg};
                        state_next     = S_MOT_WAIT;
                    end
                end
            end

            S_MUL_ND:
            begin
                if (!mul0_rsp.busy && !mul1_rsp.busy)
                begin
                    if (dms_zero_reg)
                    begin
                        state_next = S_ERR_START;
                    end
                    else
                    begin
                        rem_next     = mul0_rsp.product[NUM_W-1:0];
                        dv_next      = {mul1_rsp.product[DEN_W-1:0], {(QUO_W-1){1'b0}}};
                        quo_next     = '0;
                        div_cnt_next = DIV_CNT_W'(QUO_W - 1);
                        state_next   = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dv_reg[NUM_W-1:0];
                end
                quo_next     = {quo_reg[QUO_W-2:0], div_ge};
                dv_next      = {1'b0, dv_reg[DV_W-1:1]};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    state_next = S_VEL;
                end
            end

            S_VEL:
            begin
                if (quo_reg[QUO_W-1])
                begin
                    measured_next = neg_reg ? VEL_NEG_MIN : VEL_POS_MAX;
                end
                else
                begin
                    measured_next = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                end
                state_next = S_ERR_START;
            end

            S_ERR_START:
            begin
                err_next       = err_calc;
                mul0_req.start = 1'b1;
                mul0_req.a     = {{(MUL_A_W-GAIN_W){1'b0}}, gain_reg};
                mul0_req.b     = {{(MUL_B_W-ERR_W){1'b0}},
                                  (err_calc[ERR_W-1] ? (~err_calc + 1'b1) : err_calc)};
                state_next     = S_ERR_WAIT;
            end

            S_ERR_WAIT:
            begin
                if (!mul0_rsp.busy)
                begin
                    state_next = S_DRIVE;
                end
            end

            S_DRIVE:
            begin
                drive_next    = drive_new;
                prev_err_next = err_reg;
                if (sign_change)
                begin
                    held_next    = drive_new;
                    first_next   = 1'b0;
                    crossed_next = 1'b1;
                end
                state_next = S_MOT_START;
            end

            S_MOT_START:
            begin
                mul0_req.start = 1'b1;
                mul0_req.a     = {{(MUL_A_W-DRV_W){1'b0}}, drive_reg};
                mul0_req.b     = {{(MUL_B_W-PWR_W){1'b0}}, power_reg};
                state_next     = S_MOT_WAIT;
            end

            S_MOT_WAIT:
            begin
                if (!mul0_rsp.busy && out_free)
                begin
                    motor_next       = motor_raw[MOT_W] ? MOTOR_MAX : motor_raw[MOT_W-1:0];
                    rpm_next         = measured_reg;
                    crossed_out_next = crossed_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            gain_reg        <= GAIN_RESET;
            tpr_reg         <= TPR_RESET;
            power_reg       <= POWER_RESET;
            target_reg      <= '0;
            measured_reg    <= '0;
            prev_err_reg    <= '0;
            drive_reg       <= '0;
            estimate_reg    <= '0;
            held_reg        <= '0;
            first_reg       <= 1'b1;
            prev_count_reg  <= '0;
            prev_time_reg   <= '0;
            out_valid_reg   <= 1'b0;
            div_cnt_reg     <= '0;
            crossed_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            gain_reg        <= gain_next;
            tpr_reg         <= tpr_next;
            power_reg       <= power_next;
            target_reg      <= target_next;
            measured_reg    <= measured_next;
            prev_err_reg    <= prev_err_next;
            drive_reg       <= drive_next;
            estimate_reg    <= estimate_next;
            held_reg        <= held_next;
            first_reg       <= first_next;
            prev_count_reg  <= prev_count_next;
            prev_time_reg   <= prev_time_next;
            out_valid_reg   <= out_valid_next;
            div_cnt_reg     <= div_cnt_next;
            crossed_reg     <= crossed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        motor_reg       <= motor_next;
        rpm_reg         <= rpm_next;
        crossed_out_reg <= crossed_out_next;
        neg_reg         <= neg_next;
        dms_zero_reg    <= dms_zero_next;
        rem_reg         <= rem_next;
        dv_reg          <= dv_next;
        quo_reg         <= quo_next;
        err_reg         <= err_next;
    end

    a_div_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> !mul0_rsp.busy && !mul1_rsp.busy)
        else $error("multiplier busy during divide");
    a_set_arms: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && command == CMD_SET |=> first_reg && held_reg == '0)
        else $error("set transaction did not arm first crossing");
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRIVE |=> drive_reg <= FULL_DRIVE)
        else $error("drive above full scale");
    a_cross_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRIVE && sign_change |=> crossed_reg && held_reg == drive_reg)
        else $error("crossing did not update held drive");
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MOT_WAIT && !mul0_rsp.busy && out_free
        |=> out_valid_reg && state_reg == S_IDLE)
        else $error("finished transaction not presented");

endmodule

>>> verif/flywheel_take_back_half_controller_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the take-back-half flywheel velocity controller.
// Depends on tbh_pkg and the flywheel_take_back_half_controller RTL; needs no files.
module flywheel_take_back_half_controller_tb;
    import tbh_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [MOT_W-1:0] motor;
        logic [VEL_W-1:0] rpm;
        logic             crossed;
    } motor_result_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    // Tracks the controller state and queues the expected output transactions.
    class drive_tracker;
        logic [GAIN_W-1:0] gain_q24;
        logic [TPR_W-1:0]  ticks_rev;
        logic [PWR_W-1:0]  power_scale;
        longint            tgt_rpm;
        longint            speed_rpm;
        longint            last_err;
        longint            drive_q24;
        longint            est_q24;
        longint            hold_q24;
        bit                first_pending;
        logic [31:0]       count_prev;
        logic [31:0]       time_prev;
        motor_result_t     expected_outputs[$];
        int                mismatches;
        int                sets;
        int                samples;
        int                crossings;
        int                checked;

        function new();
            gain_q24      = GAIN_RESET;
            ticks_rev     = TPR_RESET;
            power_scale   = POWER_RESET;
            tgt_rpm       = 0;
            speed_rpm     = 0;
            last_err      = 0;
            drive_q24     = 0;
            est_q24       = 0;
            hold_q24      = 0;
            first_pending = 1'b1;
            count_prev    = '0;
            time_prev     = '0;
            mismatches    = 0;
            sets          = 0;
            samples       = 0;
            crossings     = 0;
            checked       = 0;
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_LOOP_GAIN)
                gain_q24 = data[GAIN_W-1:0];
            else if (idx == CFG_REV_TICKS)
                ticks_rev = data[TPR_W-1:0];
            else if (idx == CFG_MAX_POWER)
                power_scale = data[PWR_W-1:0];
        endfunction

        function int sgn(longint x);
            if (x > 0)
                return 1;
            if (x < 0)
                return -1;
            return 0;
        endfunction

        function void note_command(command_t cmd, logic signed [VEL_W-1:0] tgt,
                                   logic [DRV_W-1:0] pd, logic [31:0] cnt, logic [31:0] tm);
            logic [31:0]   dms;
            logic [31:0]   dcnt;
            longint        denc;
            longint        tpr_eff;
            longint        q;
            longint        err;
            longint        m;
            motor_result_t r;
            r.crossed = 1'b0;
            if (cmd == CMD_SET)
            begin
                sets++;
                tgt_rpm       = longint'(tgt);
                last_err      = tgt_rpm - speed_rpm;
                est_q24       = (pd > FULL_DRIVE) ? longint'(FULL_DRIVE) : longint'(pd);
                first_pending = 1'b1;
                hold_q24      = 0;
            end
            else
            begin
                samples++;
                dms        = tm - time_prev;
                dcnt       = cnt - count_prev;
                denc       = longint'($signed(dcnt));
                time_prev  = tm;
                count_prev = cnt;
                if (dms != 0)
                begin
                    tpr_eff = (ticks_rev == 0) ? 1 : longint'(ticks_rev);
                    q = (denc * longint'(RPM_SCALE)) / (longint'(dms) * tpr_eff);
                    if (q > 32767)
                        q = 32767;
                    if (q < -32768)
                        q = -32768;
                    speed_rpm = q;
                end
                err = tgt_rpm - speed_rpm;
                drive_q24 += err * longint'(gain_q24);
                if (drive_q24 > longint'(FULL_DRIVE))
                    drive_q24 = longint'(FULL_DRIVE);
                if (drive_q24 < 0)
                    drive_q24 = 0;
                if (sgn(err) != sgn(last_err))
                begin
                    if (first_pending)
                    begin
                        drive_q24     = est_q24;
                        first_pending = 1'b0;
                    end
                    else
                    begin
                        drive_q24 = (drive_q24 + hold_q24) >>> 1;
                    end
                    hold_q24  = drive_q24;
                    r.crossed = 1'b1;
                    crossings++;
                end
                last_err = err;
            end
            m = (drive_q24 * longint'(power_scale) + longint'(HALF_LSB)) >>> 24;
            if (m > 127)
                m = 127;
            if (m < 0)
                m = 0;
            r.motor = m[MOT_W-1:0];
            r.rpm   = speed_rpm[VEL_W-1:0];
            expected_outputs.push_back(r);
        endfunction

        function void check_output(logic [MOT_W-1:0] mot, logic [VEL_W-1:0] rpm, logic crs);
            motor_result_t e;
            if (expected_outputs.size() == 0)
            begin
                $error("unexpected output transaction: motor_command %0d measured_rpm %0d crossed %0d",
                       mot, $signed(rpm), crs);
                mismatches++;
                return;
            end
            e = expected_outputs.pop_front();
            checked++;
            if (mot !== e.motor)
            begin
                $error("motor_command: expected %0d, actual %0d", e.motor, mot);
                mismatches++;
            end
            if (rpm !== e.rpm)
            begin
                $error("measured_rpm: expected %0d, actual %0d", $signed(e.rpm), $signed(rpm));
                mismatches++;
            end
            if (crs !== e.crossed)
            begin
                $error("crossed: expected %0d, actual %0d", e.crossed, crs);
                mismatches++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n           = 1'b0;
    logic                      in_valid        = 1'b0;
    logic                      in_ready;
    command_t                  command         = CMD_SET;
    logic signed [VEL_W-1:0]   target_rpm      = '0;
    logic [DRV_W-1:0]          open_loop_drive = '0;
    logic signed [CNT_W-1:0]   encoder_count   = '0;
    logic [TIME_W-1:0]         time_ms         = '0;
    logic                      out_valid;
    logic                      out_ready       = 1'b0;
    logic [MOT_W-1:0]          motor_command;
    logic signed [VEL_W-1:0]   measured_rpm;
    logic                      crossed;
    logic                      cfg_valid       = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index       = '0;
    logic [CFG_DATA_W-1:0]     cfg_data        = '0;

    drive_tracker sb;
    bit           valid_held  = 1'b0;
    int           burst_left  = 0;
    int           items_sent  = 0;
    int           settings    = 1;
    logic [31:0]  last_count  = '0;
    logic [31:0]  last_time   = '0;
    logic [5:0]   rx_phase    = '0;
    rx_mode_t     rx_mode     = RX_OPEN;

    flywheel_take_back_half_controller u_dut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // receiver stall pattern, mode reshuffled each time rx_phase wraps to zero
    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 6'd1;
        if (rx_phase == 6'd0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:     out_ready <= 1'b1;
            RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: out_ready <= (rx_phase[1:0] == 2'b11);
            default:     out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_output(motor_command, measured_rpm, crossed);
    end

    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            if (valid_held)
            begin
                in_valid   <= 1'b0;
                valid_held = 1'b0;
            end
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_item(command_t cmd, logic signed [VEL_W-1:0] tgt,
                             logic [DRV_W-1:0] pd, logic [31:0] cnt, logic [31:0] tm);
        in_valid        <= 1'b1;
        command         <= cmd;
        target_rpm      <= tgt;
        open_loop_drive <= pd;
        encoder_count   <= cnt;
        time_ms         <= tm;
        valid_held      = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_command(cmd, tgt, pd, cnt, tm);
        items_sent++;
        if (cmd == CMD_SAMPLE)
        begin
            last_count = cnt;
            last_time  = tm;
        end
        pace();
    endtask

    task automatic send_set(logic signed [VEL_W-1:0] tgt, logic [DRV_W-1:0] pd);
        send_item(CMD_SET, tgt, pd, $urandom, $urandom);
    endtask

    task automatic send_sample(logic [31:0] cnt, logic [31:0] tm);
        send_item(CMD_SAMPLE, 16'($urandom), 25'($urandom), cnt, tm);
    endtask

    // encoder advance for a flywheel spinning at rpm over a tick of 0 or 20..50 ms
    task automatic plant_sample(longint rpm);
        logic [31:0] dms;
        longint      tpr_eff;
        longint      dcount;
        dms     = ($urandom_range(0, 19) == 0) ? 32'd0 : 32'($urandom_range(20, 50));
        tpr_eff = (sb.ticks_rev == 0) ? 1 : longint'(sb.ticks_rev);
        dcount  = rpm * tpr_eff * longint'(dms) / 60000;
        send_sample(last_count + 32'(dcount), last_time + dms);
    endtask

    task automatic wait_idle();
        if (valid_held)
        begin
            in_valid   <= 1'b0;
            valid_held = 1'b0;
        end
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_register(idx, data);
    endtask

    task automatic configure(logic [GAIN_W-1:0] g, logic [TPR_W-1:0] t, logic [PWR_W-1:0] p);
        write_reg(CFG_LOOP_GAIN, CFG_DATA_W'(g));
        write_reg(CFG_REV_TICKS, CFG_DATA_W'(t));
        write_reg(CFG_MAX_POWER, CFG_DATA_W'(p));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic directed_items();
        int speeds[5] = '{1400, 1650, 1450, 1540, 1500};
        send_sample(32'd0, 32'd0);
        send_set(16'sh7FFF, 25'h1FF_FFFF);
        send_sample(32'd261, 32'd60000);
        send_sample(32'h7FFF_FFFF, 32'd60001);
        send_sample(32'h0000_0000, 32'd60002);
        send_set(16'sh8000, 25'd0);
        send_sample(32'h8000_0000, 32'hFFFF_FFF0);
        send_sample(32'h7FFF_FFFF, 32'h0000_0010);
        send_set(16'sd0, FULL_DRIVE);
        send_sample(32'h7FFF_FFFF, 32'h0000_0030);
        send_sample(32'h8000_0000, 32'h0000_0031);
        send_sample(32'h8000_0000, 32'h0000_0040);
        send_set(16'sd1500, 25'd16777217);
        foreach (speeds[i])
            plant_sample(longint'(speeds[i]));
        send_sample(last_count - 32'd1, last_time - 32'd1);
        send_set(-16'sd1, 25'd1);
        send_sample(last_count + 32'd1, last_time + 32'd1);
        send_sample(last_count, last_time + 32'd1);
    endtask

    // set point followed by a run of ticks oscillating about it
    task automatic spin_run();
        logic signed [VEL_W-1:0] tgt;
        logic [DRV_W-1:0]        pd;
        longint                  offset;
        longint                  rpm;
        int                      r;
        r = $urandom_range(0, 19);
        if (r < 13)
            tgt = 16'($urandom_range(300, 3600));
        else if (r < 16)
            tgt = 16'(-int'($urandom_range(300, 3600)));
        else if (r < 17)
            tgt = '0;
        else
            tgt = 16'($urandom);
        r = $urandom_range(0, 9);
        if (r < 7)
            pd = 25'($urandom_range(0, 16777216));
        else if (r < 9)
            pd = 25'($urandom);
        else
            pd = FULL_DRIVE;
        send_set(tgt, pd);
        offset = longint'(int'($urandom_range(0, 2000)) - 1000);
        repeat ($urandom_range(6, 30))
        begin
            if ($urandom_range(0, 9) < 6)
                offset = -offset * longint'($urandom_range(3, 9)) / 10;
            else
                offset = offset * longint'($urandom_range(5, 9)) / 10;
            offset += longint'(int'($urandom_range(0, 40)) - 20);
            rpm = longint'(tgt) + offset;
            if (rpm > 32767)
                rpm = 32767;
            if (rpm < -32768)
                rpm = -32768;
            plant_sample(rpm);
        end
    endtask

    task automatic random_items(int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    send_item(command_t'($urandom_range(0, 1)), 16'($urandom),
                              25'($urandom), $urandom, $urandom);
            end
            else
            begin
                spin_run();
            end
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("flywheel_take_back_half_controller_tb: errors");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        random_items(100);

        wait_idle();
        configure(24'hFF_FFFF, 12'd1, 7'd0);
        random_items(110);

        wait_idle();
        configure(24'd0, 12'd4095, 7'd127);
        random_items(110);

        wait_idle();
        write_reg(CFG_SPARE, 24'($urandom));
        configure(GAIN_RESET, 12'd0, 7'd64);
        random_items(110);

        wait_idle();
        configure(24'($urandom_range(1000, 200000)), 12'($urandom_range(1, 4095)),
                  7'($urandom_range(1, 127)));
        random_items(60);
        wait_idle();
        random_items(60);

        wait_idle();
        configure(GAIN_RESET, TPR_RESET, POWER_RESET);
        random_items(110);

        wait_idle();
        repeat (80) @(posedge clk);

        $display("covered %0d set and %0d sample transactions, %0d error sign crossings",
                 sb.sets, sb.samples, sb.crossings);
        $display("%0d results checked across %0d register settings", sb.checked, settings);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("flywheel_take_back_half_controller_tb: clean");
        else
            $display("flywheel_take_back_half_controller_tb: errors");
        $finish;
    end

endmodule

>>> files.f
src/tbh_pkg.sv
src/tbh_mul.sv
src/flywheel_take_back_half_controller.sv
verif/flywheel_take_back_half_controller_tb.sv
